[rtl/lifn_pkg.sv]
// Shared constants, register map and reset values for the LIF neuron step block.
`timescale 1ns / 1ps
`default_nettype none

package lifn_pkg;

	localparam int LIFN_VOLT_WIDTH    = 32;
	localparam int LIFN_REFRACT_WIDTH = 16;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_REST_POTENTIAL   = 3'd0,
		REG_RESET_POTENTIAL  = 3'd1,
		REG_FIRE_THRESHOLD   = 3'd2,
		REG_BIAS_CURRENT     = 3'd3,
		REG_LEAK_GAIN        = 3'd4,
		REG_INPUT_GAIN       = 3'd5,
		REG_REFRACTORY_TICKS = 3'd6
	} cfg_reg_t;

	localparam logic signed [31:0] REST_POTENTIAL_RST   = -32'sd4587520;
	localparam logic signed [31:0] RESET_POTENTIAL_RST  = -32'sd4587520;
	localparam logic signed [31:0] FIRE_THRESHOLD_RST   = -32'sd3538944;
	localparam logic signed [31:0] BIAS_CURRENT_RST     = 32'sd0;
	localparam logic [15:0]        LEAK_GAIN_RST        = 16'd655;
	localparam logic [23:0]        INPUT_GAIN_RST       = 24'd8389;
	localparam logic [15:0]        REFRACTORY_TICKS_RST = 16'd20;

	// membrane level after reset, before saturation to the voltage width
	localparam longint MEMBRANE_RST = -64'sd4587520;

endpackage

`default_nettype wire

[rtl/lif_neuron_euler_step_top.sv]
// Top level of the leaky integrate-and-fire neuron, one forward-Euler tick per request.
`timescale 1ns / 1ps
`default_nettype none

// Leaky integrate-and-fire neuron, one simulation tick per input request. Each request
// carries the tick's summed spike drive and its input current; each gives one result
// with the spike flag and the membrane voltage after the tick (signed Q15.16 mV).
// Flow: a request is taken into the input register; once the result register is free,
// the tick is computed from the input register and loaded into the result register,
// which offers the result until it is taken. One request is taken every cycle while
// results are not stalled: the tick update (two multipliers, a four-term saturating
// add and the threshold compare) is combinational logic between the input register
// and the result register, which also closes the
// loop through the membrane state. A full input register stalls only while the result
// register holds a result that is stalled. The configuration port is always ready;
// write it only while no request is in flight. Index 7 is ignored. The current of a
// tick acts on the following tick. Voltages saturate to VOLT_WIDTH bits internally and
// to 32 bits on output.

module lif_neuron_euler_step_top
	import lifn_pkg::*;
#(
	parameter int VOLT_WIDTH    = LIFN_VOLT_WIDTH,
	parameter int REFRACT_WIDTH = LIFN_REFRACT_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// tick requests
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  signed [31:0]                spike_drive,
	input  wire  signed [31:0]                current_in,
	// tick results
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              spike_out,
	output logic signed [31:0]                membrane_voltage,
	// configuration writes
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire         [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire         [CFG_DATA_WIDTH-1:0]  cfg_data
);

	// widths of the datapath
	localparam int CW = (VOLT_WIDTH > 32) ? VOLT_WIDTH : 32;   // compare width
	localparam int DW = CW + 1;                                // rest - v
	localparam int LPW = DW + 17;                              // leak product
	localparam int IPW = 33 + 25;                              // input product
	localparam int SW = DW + 3;                                // four-term sum

	localparam logic signed [SW-1:0] SUM_MAX = SW'({1'b0, {(VOLT_WIDTH-1){1'b1}}});
	localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
	localparam logic signed [CW-1:0] VC_MAX  = CW'({1'b0, {(VOLT_WIDTH-1){1'b1}}});
	localparam logic signed [CW-1:0] VC_MIN  = ~VC_MAX;
	localparam logic signed [CW-1:0] OUT_MAX = CW'({1'b0, {31{1'b1}}});
	localparam logic signed [CW-1:0] OUT_MIN = ~OUT_MAX;

	localparam longint MEM_MAX_L = (64'sd1 <<< (VOLT_WIDTH - 1)) - 64'sd1;
	localparam longint MEM_MIN_L = -MEM_MAX_L - 64'sd1;
	localparam logic signed [VOLT_WIDTH-1:0] MEM_RST = VOLT_WIDTH'(
		(MEMBRANE_RST > MEM_MAX_L) ? MEM_MAX_L :
		((MEMBRANE_RST < MEM_MIN_L) ? MEM_MIN_L : MEMBRANE_RST));

	// configuration registers
	logic signed [31:0] rest_potential_q;
	logic signed [31:0] reset_potential_q;
	logic signed [31:0] fire_threshold_q;
	logic signed [31:0] bias_current_q;
	logic        [15:0] leak_gain_q;
	logic        [23:0] input_gain_q;
	logic        [15:0] refractory_ticks_q;

	// neuron state
	logic signed [VOLT_WIDTH-1:0] membrane_q;
	logic signed [31:0]           held_current_q;
	logic [REFRACT_WIDTH-1:0]     refractory_q;

	// input register
	logic                in_valid_s1;
	logic signed [31:0]  spike_drive_s1;
	logic signed [31:0]  current_in_s1;

	// result register
	logic                out_valid_q;
	logic                spike_out_q;
	logic signed [31:0]  membrane_voltage_q;

	// datapath
	logic                         advance;
	logic                         update;
	logic signed [DW-1:0]         diff;
	logic signed [LPW-1:0]        leak_prod;
	logic signed [32:0]           isum;
	logic signed [IPW-1:0]        inp_prod;
	logic signed [SW-1:0]         sum;
	logic signed [VOLT_WIDTH-1:0] integ;
	logic signed [CW-1:0]         integ_ext;
	logic signed [CW-1:0]         reset_ext;
	logic signed [VOLT_WIDTH-1:0] reset_sat;
	logic                         fire;
	logic signed [VOLT_WIDTH-1:0] membrane_next;
	logic signed [CW-1:0]         membrane_next_ext;
	logic signed [31:0]           voltage_out;
	logic [REFRACT_WIDTH-1:0]     refractory_next;

	// The result register frees up when empty or when its result is taken; hold the
	// input register otherwise.
	assign advance  = !out_valid_q || !out_stall;
	assign update   = advance && in_valid_s1;
	assign in_stall = in_valid_s1 && !advance;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_potential_q   <= REST_POTENTIAL_RST;
			reset_potential_q  <= RESET_POTENTIAL_RST;
			fire_threshold_q   <= FIRE_THRESHOLD_RST;
			bias_current_q     <= BIAS_CURRENT_RST;
			leak_gain_q        <= LEAK_GAIN_RST;
			input_gain_q       <= INPUT_GAIN_RST;
			refractory_ticks_q <= REFRACTORY_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_REST_POTENTIAL:   rest_potential_q   <= $signed(cfg_data);
				REG_RESET_POTENTIAL:  reset_potential_q  <= $signed(cfg_data);
				REG_FIRE_THRESHOLD:   fire_threshold_q   <= $signed(cfg_data);
				REG_BIAS_CURRENT:     bias_current_q     <= $signed(cfg_data);
				REG_LEAK_GAIN:        leak_gain_q        <= cfg_data[15:0];
				REG_INPUT_GAIN:       input_gain_q       <= cfg_data[23:0];
				REG_REFRACTORY_TICKS: refractory_ticks_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// tick update
	always_comb begin
		diff      = DW'(rest_potential_q) - DW'(membrane_q);
		// exact product, arithmetic shift rounds toward minus infinity
		leak_prod = diff * $signed({1'b0, leak_gain_q});
		isum      = 33'(bias_current_q) + 33'(held_current_q);
		inp_prod  = isum * $signed({1'b0, input_gain_q});
		sum       = SW'(membrane_q) + SW'(leak_prod >>> 16) + SW'(inp_prod >>> 24)
		          + SW'(spike_drive_s1);

		// refractory ticks leave the voltage alone and drop the drive
		if (refractory_q != '0) begin
			integ = membrane_q;
		end else if (sum > SUM_MAX) begin
			integ = VOLT_WIDTH'(SUM_MAX);
		end else if (sum < SUM_MIN) begin
			integ = VOLT_WIDTH'(SUM_MIN);
		end else begin
			integ = VOLT_WIDTH'(sum);
		end

		integ_ext = CW'(integ);
		fire      = integ_ext >= CW'(fire_threshold_q);

		reset_ext = CW'(reset_potential_q);
		if (reset_ext > VC_MAX) begin
			reset_sat = VOLT_WIDTH'(VC_MAX);
		end else if (reset_ext < VC_MIN) begin
			reset_sat = VOLT_WIDTH'(VC_MIN);
		end else begin
			reset_sat = VOLT_WIDTH'(reset_ext);
		end

		membrane_next     = fire ? reset_sat : integ;
		membrane_next_ext = CW'(membrane_next);
		if (membrane_next_ext > OUT_MAX) begin
			voltage_out = 32'(OUT_MAX);
		end else if (membrane_next_ext < OUT_MIN) begin
			voltage_out = 32'(OUT_MIN);
		end else begin
			voltage_out = 32'(membrane_next_ext);
		end

		// a spike reloads the count even while refractory
		if (fire) begin
			refractory_next = REFRACT_WIDTH'(refractory_ticks_q);
		end else if (refractory_q != '0) begin
			refractory_next = refractory_q - REFRACT_WIDTH'(1);
		end else begin
			refractory_next = refractory_q;
		end
	end

	// input register: take a request whenever it is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			spike_drive_s1 <= spike_drive;
			current_in_s1  <= current_in;
		end
	end

	// neuron state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membrane_q     <= MEM_RST;
			held_current_q <= '0;
			refractory_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= in_valid_s1;
			end
			if (update) begin
				membrane_q     <= membrane_next;
				held_current_q <= current_in_s1;
				refractory_q   <= refractory_next;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (update) begin
			spike_out_q        <= fire;
			membrane_voltage_q <= voltage_out;
		end
	end

	assign out_valid        = out_valid_q;
	assign spike_out        = spike_out_q;
	assign membrane_voltage = membrane_voltage_q;

`ifndef NO_ASSERTIONS
	// a spike loads the refractory count
	a_fire_loads_count: assert property (@(posedge clk) disable iff (!arst_n)
		(update && fire) |=> (refractory_q == REFRACT_WIDTH'($past(refractory_ticks_q))))
		else $error("refractory count not loaded after spike");

	// a refractory tick without a spike leaves the voltage alone
	a_refractory_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(update && (refractory_q != '0) && !fire) |=> $stable(membrane_q))
		else $error("membrane moved during refractory tick");

	// the input side stalls only behind a full input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1)
		else $error("input stalled with empty input register");

	// a result leaves only when taken
	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(!out_stall))
		else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the LIF neuron Euler step block: tick requests, results, registers.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import lifn_pkg::*;

	// One millivolt in Q15.16.
	localparam int MV = 65536;
	localparam logic signed [31:0] MAX_LEVEL = 32'sh7FFFFFFF;
	localparam logic signed [31:0] MIN_LEVEL = 32'sh80000000;
	localparam longint VOLT_MAX = 64'sd2147483647;
	localparam longint VOLT_MIN = -64'sd2147483648;
	// The register map leaves this index unused; writes to it must change nothing.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
	localparam int TICKS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		logic signed [31:0] drive;
		logic signed [31:0] current;
	} tick_request_t;

	typedef struct {
		logic               spike;
		logic signed [31:0] volt;
	} tick_result_t;

	typedef struct {
		logic [CFG_INDEX_WIDTH-1:0] index;
		logic [CFG_DATA_WIDTH-1:0]  value;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [31:0]         spike_drive = '0;
	logic signed [31:0]         current_in = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       spike_out;
	logic signed [31:0]         membrane_voltage;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

	// Requests waiting to be sent, results predicted but not yet seen, register writes to send.
	tick_request_t pending_ticks[$];
	tick_result_t  awaited_results[$];
	reg_write_t    reg_writes[$];

	// Shadow of the register file, as the block should hold it.
	logic signed [31:0] cfg_rest    = REST_POTENTIAL_RST;
	logic signed [31:0] cfg_reset_v = RESET_POTENTIAL_RST;
	logic signed [31:0] cfg_thresh  = FIRE_THRESHOLD_RST;
	logic signed [31:0] cfg_bias    = BIAS_CURRENT_RST;
	logic [15:0]        cfg_leak    = LEAK_GAIN_RST;
	logic [23:0]        cfg_igain   = INPUT_GAIN_RST;
	logic [15:0]        cfg_refract = REFRACTORY_TICKS_RST;

	// Shadow of the neuron state.
	longint      nrn_v    = MEMBRANE_RST;
	longint      nrn_held = 0;
	logic [15:0] nrn_refr = '0;

	// Set for a phase that runs with no idling on either side.
	bit calm = 1'b0;
	int errors = 0;

	lif_neuron_euler_step_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.spike_drive      (spike_drive),
		.current_in       (current_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.spike_out        (spike_out),
		.membrane_voltage (membrane_voltage),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the shadow neuron by one tick and return the result the block should give.
	function automatic tick_result_t advance_neuron(logic signed [31:0] drive,
			logic signed [31:0] cur);
		tick_result_t r;
		longint gain;
		longint diff;
		longint leak_term;
		longint input_term;
		longint sum;
		r.spike = 1'b0;
		if (nrn_refr == 0) begin
			// Exact products, then an arithmetic shift: both terms round toward minus infinity.
			gain = cfg_leak;
			diff = longint'(cfg_rest) - nrn_v;
			leak_term = (diff * gain) >>> 16;
			gain = cfg_igain;
			input_term = ((longint'(cfg_bias) + nrn_held) * gain) >>> 24;
			sum = nrn_v + leak_term + input_term + longint'(drive);
			if (sum > VOLT_MAX) begin
				nrn_v = VOLT_MAX;
			end else if (sum < VOLT_MIN) begin
				nrn_v = VOLT_MIN;
			end else begin
				nrn_v = sum;
			end
		end else begin
			// Refractory: count down and drop the tick's drive.
			nrn_refr = nrn_refr - 1'b1;
		end
		// The threshold test runs on every tick, refractory or not.
		if (nrn_v >= longint'(cfg_thresh)) begin
			r.spike = 1'b1;
			nrn_refr = cfg_refract;
			nrn_v = longint'(cfg_reset_v);
		end
		// This tick's current acts on the next one.
		nrn_held = cur;
		r.volt = nrn_v[31:0];
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Idle with a chance of about one in ten, except during a calm phase.
	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 10);
	endfunction

	// Mostly small levels around zero, sometimes the extremes or any 32-bit word.
	function automatic logic signed [31:0] pick_level(int span);
		int roll;
		roll = $urandom_range(99);
		if (roll < 2) return MAX_LEVEL;
		if (roll < 4) return MIN_LEVEL;
		if (roll < 6) return '0;
		if (roll < 16) return $urandom();
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Request driver: present the oldest pending tick, hold it while stalled, predict on accept.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				awaited_results.push_back(advance_neuron(spike_drive, current_in));
				pending_ticks.delete(0);
			end
			// A stalled request stays exactly as it is.
			if (!(in_valid && in_stall)) begin
				if (pending_ticks.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					spike_drive <= pending_ticks[0].drive;
					current_in <= pending_ticks[0].current;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest prediction, stall at random.
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result spike=%b v=%0d",
						spike_out, membrane_voltage));
				end else begin
					want = awaited_results.pop_front();
					if (spike_out !== want.spike) begin
						flag_mismatch($sformatf("spike_out %b, predicted %b",
							spike_out, want.spike));
					end
					if (membrane_voltage !== want.volt) begin
						flag_mismatch($sformatf("membrane_voltage %0d, predicted %0d",
							membrane_voltage, want.volt));
					end
				end
			end
			out_stall <= take_break();
		end
	end

	// Register writer: send queued writes one at a time, update the shadow when one lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_REST_POTENTIAL: begin
						cfg_rest = cfg_data;
					end
					REG_RESET_POTENTIAL: begin
						cfg_reset_v = cfg_data;
					end
					REG_FIRE_THRESHOLD: begin
						cfg_thresh = cfg_data;
					end
					REG_BIAS_CURRENT: begin
						cfg_bias = cfg_data;
					end
					REG_LEAK_GAIN: begin
						cfg_leak = cfg_data[15:0];
					end
					REG_INPUT_GAIN: begin
						cfg_igain = cfg_data[23:0];
					end
					REG_REFRACTORY_TICKS: begin
						cfg_refract = cfg_data[15:0];
					end
					default: begin
					end
				endcase
				reg_writes.delete(0);
			end
			if (!(cfg_valid && !cfg_ready)) begin
				if (reg_writes.size() != 0) begin
					cfg_valid <= 1'b1;
					cfg_index <= reg_writes[0].index;
					cfg_data <= reg_writes[0].value;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	task automatic queue_tick(logic signed [31:0] drive, logic signed [31:0] cur);
		tick_request_t t;
		t.drive = drive;
		t.current = cur;
		pending_ticks.push_back(t);
	endtask

	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
		reg_write_t w;
		w.index = idx;
		w.value = value;
		reg_writes.push_back(w);
	endtask

	// Wait until every queued register write has landed.
	task automatic settle_regs();
		while (reg_writes.size() != 0 || cfg_valid) @(posedge clk);
	endtask

	// Hold off until every request is sent and every predicted result has come back.
	task automatic drain_ticks();
		while (pending_ticks.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random register set around a biologically plausible operating point, with outliers.
	task automatic scramble_regs();
		int rest;
		rest = -70 * MV + int'($urandom_range(20 * MV)) - 10 * MV;
		if ($urandom_range(9) == 0) rest = $urandom();
		write_reg(REG_REST_POTENTIAL, rest);
		write_reg(REG_RESET_POTENTIAL, ($urandom_range(9) == 0) ? $urandom() :
			rest + int'($urandom_range(10 * MV)) - 5 * MV);
		write_reg(REG_FIRE_THRESHOLD, ($urandom_range(9) == 0) ? $urandom() :
			rest + int'($urandom_range(30 * MV)));
		write_reg(REG_BIAS_CURRENT, ($urandom_range(4) == 0) ? $urandom() :
			int'($urandom_range(400 * MV)) - 200 * MV);
		write_reg(REG_LEAK_GAIN, ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) :
			$urandom_range(4000));
		write_reg(REG_INPUT_GAIN, ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF) :
			$urandom_range(1 << 16));
		write_reg(REG_REFRACTORY_TICKS, $urandom_range(7));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short refractory window so its end is reached quickly.
		write_reg(REG_REFRACTORY_TICKS, 3);
		settle_regs();
		queue_tick(0, 0);
		queue_tick(20 * MV, 0);             // crosses -54 mV and fires
		queue_tick(MAX_LEVEL, MAX_LEVEL);   // refractory, drive dropped
		queue_tick(MIN_LEVEL, MIN_LEVEL);
		queue_tick(0, 0);
		queue_tick(MAX_LEVEL, 0);           // largest drive, fires
		queue_tick(0, MAX_LEVEL);
		queue_tick(-1, MAX_LEVEL);
		queue_tick(1, MAX_LEVEL);
		queue_tick(MIN_LEVEL, MIN_LEVEL);   // largest held current, saturates low
		queue_tick(0, MIN_LEVEL);
		queue_tick(-5 * MV, 0);
		queue_tick(3 * MV, 12345);
		drain_ticks();

		// Reset level above the threshold: fire on every tick, refractory or not.
		write_reg(REG_FIRE_THRESHOLD, -75 * MV);
		write_reg(REG_REFRACTORY_TICKS, 5);
		settle_regs();
		repeat (4) queue_tick(0, 0);
		drain_ticks();

		// No refractory time at all.
		write_reg(REG_FIRE_THRESHOLD, FIRE_THRESHOLD_RST);
		write_reg(REG_REFRACTORY_TICKS, 0);
		settle_regs();
		queue_tick(20 * MV, 0);
		queue_tick(20 * MV, 0);
		queue_tick(0, 0);
		drain_ticks();

		// Threshold lowered in the middle of a refractory window.
		write_reg(REG_REFRACTORY_TICKS, 10);
		settle_regs();
		queue_tick(20 * MV, 0);
		queue_tick(0, 0);
		drain_ticks();
		write_reg(REG_FIRE_THRESHOLD, -80 * MV);
		settle_regs();
		queue_tick(0, 0);
		drain_ticks();

		// Random phases, each with its own register setting; every boundary drains fully.
		for (int p = 0; p < 10; p++) begin
			case (p)
				1: begin
					// Largest gains pulling toward the top rail.
					write_reg(REG_REST_POTENTIAL, MAX_LEVEL);
					write_reg(REG_RESET_POTENTIAL, MIN_LEVEL);
					write_reg(REG_FIRE_THRESHOLD, MAX_LEVEL);
					write_reg(REG_BIAS_CURRENT, MIN_LEVEL);
					write_reg(REG_LEAK_GAIN, 16'hFFFF);
					write_reg(REG_INPUT_GAIN, 24'hFFFFFF);
					write_reg(REG_REFRACTORY_TICKS, 1);
					write_reg(REG_UNUSED, 32'hDEAD_BEEF);
				end
				2: begin
					// No leak, no input path: only the drive and the reset on a spike move the voltage.
					write_reg(REG_REST_POTENTIAL, MIN_LEVEL);
					write_reg(REG_RESET_POTENTIAL, MAX_LEVEL);
					write_reg(REG_FIRE_THRESHOLD, int'($urandom_range(20 * MV)));
					write_reg(REG_BIAS_CURRENT, MAX_LEVEL);
					write_reg(REG_LEAK_GAIN, 0);
					write_reg(REG_INPUT_GAIN, 0);
					write_reg(REG_REFRACTORY_TICKS, 0);
				end
				5: begin
					scramble_regs();
					write_reg(REG_REFRACTORY_TICKS, 16'hFFFF);
				end
				6: begin
					// Lowest threshold: every tick fires, which also ends the long window.
					scramble_regs();
					write_reg(REG_FIRE_THRESHOLD, MIN_LEVEL);
					write_reg(REG_REFRACTORY_TICKS, 0);
				end
				default: begin
					scramble_regs();
				end
			endcase
			settle_regs();
			calm = (p == 3);
			repeat (TICKS_PER_PHASE) queue_tick(pick_level(8 * MV), pick_level(10000 * MV));
			drain_ticks();
		end
		calm = 1'b0;

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#(2_000_000);
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/lifn_pkg.sv
rtl/lif_neuron_euler_step_top.sv
test/testbench.sv
